FILE: hdl/tca_pkg.sv
package tca_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROAD_LENGTH    = 2'd0,
    CFG_MAX_SPEED      = 2'd1,
    CFG_SLOW_THRESHOLD = 2'd2,
    CFG_VEHICLE_COUNT  = 2'd3
  } cfg_idx_e;

  // input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // hash constants
  localparam logic [31:0] HASH_SEED = 32'd42;
  localparam logic [31:0] HASH_K0   = 32'h9E37_79B9;
  localparam logic [31:0] HASH_K1   = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_K2   = 32'h7FEB_352D;
  localparam logic [31:0] HASH_K3   = 32'h846C_A68B;

  // sequencer states
  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_RDPOS = 11'b000_0000_0010,
    ST_MOD   = 11'b000_0000_0100,
    ST_RDI   = 11'b000_0000_1000,
    ST_SCAN  = 11'b000_0001_0000,
    ST_HASH  = 11'b000_0010_0000,
    ST_PROP  = 11'b000_0100_0000,
    ST_RDW   = 11'b000_1000_0000,
    ST_WB    = 11'b001_0000_0000,
    ST_OUT   = 11'b010_0000_0000,
    ST_MODB  = 11'b100_0000_0000
  } state_e;

endpackage

FILE: hdl/traffic_cellular_automaton_step_core.sv
// Nagel-Schreckenberg step engine over a vehicle table.
// Input channel (in_valid_i/in_ready_o): a load request writes one table slot;
// a step request updates the first vehicle_count slots with the time_step it
// carries and emits one result per vehicle in slot order on the output
// channel (out_valid_o/out_ready_i), last_o on the final.
// Config channel (cfg_valid_i/cfg_ready_o) writes road_length, max_speed,
// slow_threshold and vehicle_count; write only while the block is idle.
// A step runs in passes: first each position is reduced modulo road_length by
// restoring subtraction, then every vehicle is fetched, scans all n slots,
// hashes its id in 4 multiply steps and writes its proposal; then a
// write-back pass runs per vehicle and waits on any output stall. The n*n
// scan sets the length of a step and the road length does not shorten it.
// in_ready_o is low for the whole step and until the last result is taken.
// A stalled receiver holds the result register and the sequencer waits on it
// before loading the next result; nothing is dropped.
// Reset restores road_length 100, max_speed 5, slow_threshold 0, count 0;
// table contents are undefined until loaded.
module traffic_cellular_automaton_step_core
  import tca_pkg::*;
#(
  parameter int MAX_VEHICLES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [32:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [5:0]  slot_i,
  input  logic [15:0] cell_req_i,
  input  logic [7:0]  speed_i,
  input  logic [1:0]  loop_number_i,
  input  logic [15:0] vehicle_tag_i,
  input  logic [31:0] time_step_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  out_slot_o,
  output logic [15:0] new_cell_o,
  output logic [7:0]  new_speed_o,
  output logic        last_o
);

  localparam int AW = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;
  localparam int CW = $clog2(MAX_VEHICLES + 1);

  typedef struct packed {
    logic [15:0] loc;
    logic [7:0]  speed;
    logic [1:0]  lp;
    logic [15:0] tag;
  } entry_t;

  // vehicle table and per-step working stores
  entry_t      tab_mem [MAX_VEHICLES];
  logic [15:0] pos_mem [MAX_VEHICLES];
  logic [7:0]  prop_mem [MAX_VEHICLES];

  // config registers
  logic [15:0] road_q;
  logic [7:0]  vmax_q;
  logic [32:0] thr_q;
  logic [6:0]  vcnt_q;

  state_e      state_q;
  logic [CW-1:0] n_q, i_q, j_q;
  logic [31:0] ts_q;
  logic [16:0] len_q;
  logic [16:0] acc_q;
  logic [4:0]  bit_q;
  logic [15:0] gap_q;
  logic [15:0] posi_q;
  logic [1:0]  loopi_q;
  entry_t      ent_q;
  logic [15:0] pos_rd_q;
  logic [7:0]  prop_rd_q;
  logic [31:0] h_q;
  logic [2:0]  hstep_q;
  logic [7:0]  v_q;
  logic        out_valid_q;
  logic [5:0]  out_slot_q;
  logic [15:0] out_cell_q;
  logic [7:0]  out_speed_q;
  logic        out_last_q;

  logic in_acc, idle;
  assign idle        = state_q == ST_IDLE;
  assign in_ready_o  = idle && !out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      road_q <= 16'd100;
      vmax_q <= 8'd5;
      thr_q  <= '0;
      vcnt_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ROAD_LENGTH:    road_q <= cfg_data_i[15:0];
        CFG_MAX_SPEED:      vmax_q <= cfg_data_i[7:0];
        CFG_SLOW_THRESHOLD: thr_q  <= cfg_data_i;
        CFG_VEHICLE_COUNT:  vcnt_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // shared multiplier for the hash, one product per cycle
  logic [31:0] mul_a, mul_b, mul_p;
  logic [63:0] mul_full;
  always_comb begin
    case (hstep_q)
      3'd0:    begin mul_a = ts_q;                   mul_b = HASH_K0; end
      3'd1:    begin mul_a = {16'd0, ent_q.tag};     mul_b = HASH_K1; end
      3'd2:    begin mul_a = h_q ^ (h_q >> 16);      mul_b = HASH_K2; end
      default: begin mul_a = h_q ^ (h_q >> 15);      mul_b = HASH_K3; end
    endcase
    mul_full = mul_a * mul_b;
    mul_p    = mul_full[31:0];
  end

  // forward distance of scanned vehicle j from vehicle i
  logic [16:0] fwd_d;
  logic [15:0] d16;
  always_comb begin
    if (pos_rd_q >= posi_q) fwd_d = {1'b0, pos_rd_q} - {1'b0, posi_q};
    else fwd_d = {1'b0, pos_rd_q} + len_q - {1'b0, posi_q};
    d16 = fwd_d[15:0];
  end

  // proposed velocity before slowdown
  logic [8:0]  vinc;
  logic [15:0] vcap;
  always_comb begin
    vinc = {1'b0, ent_q.speed} + 9'd1;
    vcap = {7'd0, vinc};
    if (vcap > {8'd0, vmax_q}) vcap = {8'd0, vmax_q};
    if (vcap > gap_q) vcap = gap_q;
  end

  // new position, sum stays below twice the length
  logic [16:0] npos;
  always_comb begin
    npos = {1'b0, pos_rd_q} + {9'd0, prop_rd_q};
    if (npos >= len_q) npos = npos - len_q;
  end

  logic [16:0] sub_len;
  assign sub_len = len_q << bit_q;

  logic [AW-1:0] ia, ja;
  assign ia = i_q[AW-1:0];
  assign ja = j_q[AW-1:0];

  // table writes and registered reads
  always_ff @(posedge clk_i) begin
    if (in_acc && command_i == CMD_LOAD && {1'b0, slot_i} < 7'(MAX_VEHICLES)) begin
      tab_mem[slot_i[AW-1:0]] <= '{cell_req_i, speed_i, loop_number_i, vehicle_tag_i};
    end else if (state_q == ST_WB) begin
      tab_mem[ia] <= '{npos[15:0], prop_rd_q, ent_q.lp, ent_q.tag};
    end
    if (state_q == ST_MODB) pos_mem[ia] <= acc_q[15:0];
    if (state_q == ST_PROP) prop_mem[ia] <= v_q;
    ent_q     <= tab_mem[(state_q == ST_SCAN) ? ja : ia];
    pos_rd_q  <= pos_mem[(state_q == ST_SCAN) ? ja : ia];
    prop_rd_q <= prop_mem[ia];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      n_q <= '0; i_q <= '0; j_q <= '0;
      ts_q <= '0; len_q <= '0; acc_q <= '0; bit_q <= '0;
      gap_q <= '0; posi_q <= '0; loopi_q <= '0; h_q <= '0;
      hstep_q <= '0; v_q <= '0;
      out_slot_q <= '0; out_cell_q <= '0; out_speed_q <= '0; out_last_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && command_i == CMD_STEP) begin
            ts_q  <= time_step_i;
            len_q <= (road_q == 16'd0) ? 17'd1 : {1'b0, road_q};
            n_q   <= (vcnt_q > 7'(MAX_VEHICLES)) ? CW'(MAX_VEHICLES) : CW'(vcnt_q);
            i_q   <= '0;
            if (vcnt_q != 7'd0) state_q <= ST_RDPOS;
          end
        end
        // read cell of vehicle i, start restoring reduction
        ST_RDPOS: state_q <= ST_MOD;
        ST_MOD: begin
          acc_q   <= {1'b0, ent_q.loc};
          bit_q   <= 5'd15;
          state_q <= ST_MODB;
        end
        ST_MODB: begin
          if (bit_q[4]) begin
            // done; pos written above with acc_q
            if (i_q + 1'b1 == n_q) begin
              i_q <= '0; state_q <= ST_RDI;
            end else begin
              i_q <= i_q + 1'b1; state_q <= ST_RDPOS;
            end
          end else begin
            if ((len_q >> (16 - bit_q)) == 17'd0 && acc_q >= sub_len)
              acc_q <= acc_q - sub_len;
            bit_q <= bit_q - 1'b1;
          end
        end
        // fetch vehicle i, then scan all j
        ST_RDI: begin
          j_q     <= '0;
          hstep_q <= 3'd0;
          gap_q   <= len_q[15:0] - 16'd1;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (j_q == '0 && hstep_q == 3'd0) begin
            posi_q  <= pos_rd_q;
            loopi_q <= ent_q.lp;
            hstep_q <= 3'd4;
            j_q     <= j_q + 1'b1;
          end else begin
            if ((j_q - 1'b1) != i_q && ent_q.lp == loopi_q && d16 != 16'd0 &&
                d16 - 16'd1 < gap_q)
              gap_q <= d16 - 16'd1;
            if (j_q == n_q) begin
              state_q <= ST_HASH; hstep_q <= 3'd0; h_q <= HASH_SEED;
            end else j_q <= j_q + 1'b1;
          end
        end
        ST_HASH: begin
          if (hstep_q < 3'd2) h_q <= h_q ^ mul_p;
          else if (hstep_q == 3'd2) h_q <= mul_p;
          else h_q <= mul_p;
          if (hstep_q == 3'd3) state_q <= ST_PROP;
          hstep_q <= hstep_q + 1'b1;
        end
        ST_PROP: begin
          v_q <= vcap[7:0];
          if (vcap != 16'd0 && {1'b0, h_q ^ (h_q >> 16)} < thr_q)
            v_q <= vcap[7:0] - 8'd1;
          hstep_q <= 3'd5;
          if (hstep_q == 3'd5) begin
            hstep_q <= 3'd0;
            if (i_q + 1'b1 == n_q) begin
              i_q <= '0; state_q <= ST_RDW;
            end else begin
              i_q <= i_q + 1'b1; state_q <= ST_RDI;
            end
          end
        end
        // write-back pass
        ST_RDW: state_q <= ST_WB;
        ST_WB: begin
          // hold until the previous result has been taken
          if (!out_valid_q) begin
            out_slot_q  <= 6'(i_q);
            out_cell_q  <= npos[15:0];
            out_speed_q <= prop_rd_q;
            out_last_q  <= (i_q + 1'b1 == n_q);
            state_q     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            if (i_q + 1'b1 == n_q) state_q <= ST_IDLE;
            else begin
              i_q <= i_q + 1'b1; state_q <= ST_RDW;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_slot_o  = out_slot_q;
  assign new_cell_o  = out_cell_q;
  assign new_speed_o = out_speed_q;
  assign last_o      = out_last_q;

  // no new request is taken while a step runs
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle |-> !in_ready_o) else $error("ready during step");
  // a result is only loaded from the output state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT)) else $error("stray result");
  // scan index never passes the count
  a_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> j_q <= n_q) else $error("scan overrun");
  // last result returns the block to idle
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && out_last_q |-> idle) else $error("last not final");

endmodule
